>>> hw/rtl/cursor_line_editor_buffer_core_defines.svh
// Assertion helpers shared by the line editor modules.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef CURSOR_LINE_EDITOR_BUFFER_CORE_DEFINES_SVH
`define CURSOR_LINE_EDITOR_BUFFER_CORE_DEFINES_SVH

// Check that an expression holds at every clock edge.
`define CLEB_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define CLEB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cleb_pkg.sv
`default_nettype none

package cleb_pkg;

    // Buffer size and derived widths
    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the stream items
    localparam int REQ_W     = 3;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 12;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 13;

    // Width that holds a read index plus the buffer size without overflow
    localparam int CMP_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

    // Stream data widths, rounded up to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LEFT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RIGHT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BOUNDARY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_DATA
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // request transaction taken this cycle
        logic finish;   // memory read data is back; complete the request
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic needs_fetch;  // offered request must read the text memory
        logic out_valid;    // result register holds an untaken result
    } t_sts;

endpackage

`default_nettype wire

>>> hw/rtl/cursor_line_editor_buffer_core.sv
`default_nettype none

// Line editor with a cursor, kept as a gap buffer in one 4096 x 8 text memory
// (one write and one registered read port). Each request transaction gives
// exactly one result transaction. Delete, insert, and every request that is
// refused or flagged load the result when taken; cursor moves and successful
// reads wait on the registered read of the text memory ahead of the write-back
// or result. A finished result waits in an output register, so the next
// request is taken in the cycle that result leaves. The text memory needs
// no clearing after reset: only entries already written are ever read.
module cursor_line_editor_buffer_core
    import cleb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // insert_char, read_index
    input  wire logic [REQ_W-1:0]     s_axis_tuser,   // req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,   // read_char, text_length, cursor_pos
    output logic      [STATUS_W-1:0]  m_axis_tuser    // status
);

    t_cmd                 w_cmd;
    t_sts                 w_sts;
    logic [STATUS_W-1:0]  w_status;
    logic [CHAR_W-1:0]    w_read_char;
    logic [OUT_CNT_W-1:0] w_text_length;
    logic [OUT_CNT_W-1:0] w_cursor_pos;

    cleb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cleb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req_type    (s_axis_tuser),
        .i_insert_char (s_axis_tdata[CHAR_W-1:0]),
        .i_read_index  (s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (w_status),
        .o_read_char   (w_read_char),
        .o_text_length (w_text_length),
        .o_cursor_pos  (w_cursor_pos)
    );

    // Pack the result, low bits first, zero fill to whole bytes
    assign m_axis_tuser = w_status;
    assign m_axis_tdata = {{(M_TDATA_W - CHAR_W - 2*OUT_CNT_W){1'b0}},
                           w_cursor_pos, w_text_length, w_read_char};

endmodule

`default_nettype wire

>>> hw/rtl/cleb_ram.sv
`default_nettype none

module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cleb_ctrl.sv
`default_nettype none

`include "cursor_line_editor_buffer_core_defines.svh"

module cleb_ctrl
    import cleb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                // take a transaction once the result register is free or draining
                o_in_ready   = !i_sts.out_valid || i_out_ready;
                o_cmd.accept = i_in_valid && o_in_ready;
                if (o_cmd.accept && i_sts.needs_fetch) begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `CLEB_ASSERT_IMPL(a_data_out_free, r_state == S_DATA, !i_sts.out_valid,
        "result register busy at completion")
    `CLEB_ASSERT_HOLDS(a_cmd_excl, !(o_cmd.accept && o_cmd.finish), "accept and finish together")
    `CLEB_ASSERT_HOLDS(a_ready_idle, !(o_in_ready && r_state == S_DATA),
        "request taken while fetching")

endmodule

`default_nettype wire

>>> hw/rtl/cleb_datapath.sv
`default_nettype none

`include "cursor_line_editor_buffer_core_defines.svh"

module cleb_datapath
    import cleb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [CHAR_W-1:0]    i_insert_char,
    input  wire logic [IDX_W-1:0]     i_read_index,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [CHAR_W-1:0]         o_read_char,
    output logic [OUT_CNT_W-1:0]      o_text_length,
    output logic [OUT_CNT_W-1:0]      o_cursor_pos
);

    // Gap buffer: text before the cursor sits at the bottom of the memory,
    // text after the cursor sits at the top, ending at the last entry.
    logic [CNT_W-1:0]    r_cursor;
    logic [CNT_W-1:0]    r_length;
    logic [REQ_W-1:0]    r_req;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [CHAR_W-1:0]   r_char;
    logic [CNT_W-1:0]    r_out_length;
    logic [CNT_W-1:0]    r_out_cursor;

    logic [CNT_W-1:0]    n_cursor;
    logic [CNT_W-1:0]    n_length;
    logic                n_out_valid;
    logic [STATUS_W-1:0] n_status;
    logic [CHAR_W-1:0]   n_char;
    logic                w_load;

    logic [CNT_W-1:0]    w_after;     // characters after the cursor
    logic                w_at_start;
    logic                w_at_end;
    logic                w_full;
    logic                w_in_range;
    logic [CMP_W-1:0]    w_upper_addr;
    logic [ADDR_W-1:0]   w_read_addr;

    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [CHAR_W-1:0]   w_wr_data;
    logic                w_rd_en;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [CHAR_W-1:0]   w_rd_data;

    // Boundary checks on the current state
    assign w_after    = r_length - r_cursor;
    assign w_at_start = (r_cursor == '0);
    assign w_at_end   = (r_cursor == r_length);
    assign w_full     = (r_length == CNT_W'(CAPACITY));
    assign w_in_range = (CMP_W'(i_read_index) < CMP_W'(r_length));

    // Map a text index to its memory entry on either side of the gap
    assign w_upper_addr = CMP_W'(i_read_index) + CMP_W'(CAPACITY) - CMP_W'(r_length);
    assign w_read_addr  = (CMP_W'(i_read_index) < CMP_W'(r_cursor))
                        ? ADDR_W'(i_read_index) : ADDR_W'(w_upper_addr);

    // Decide whether the offered request needs a memory read, and where
    always_comb begin
        o_sts.needs_fetch = 1'b0;
        o_sts.out_valid   = r_out_valid;
        w_rd_addr         = w_read_addr;
        case (i_req_type)
            REQ_LEFT: begin
                o_sts.needs_fetch = !w_at_start;
                w_rd_addr         = ADDR_W'(r_cursor - CNT_W'(1));
            end
            REQ_RIGHT: begin
                o_sts.needs_fetch = !w_at_end;
                w_rd_addr         = ADDR_W'(CNT_W'(CAPACITY) - w_after);
            end
            REQ_READ: begin
                o_sts.needs_fetch = w_in_range;
            end
            default: begin
                o_sts.needs_fetch = 1'b0;
            end
        endcase
    end
    assign w_rd_en = i_cmd.accept && o_sts.needs_fetch;

    // Memory writes: insert at the cursor, or move one character across the gap
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = ADDR_W'(r_cursor);
        w_wr_data = i_insert_char;
        if (i_cmd.accept) begin
            w_wr_en = (i_req_type == REQ_INSERT) && !w_full;
        end else if (i_cmd.finish) begin
            w_wr_data = w_rd_data;
            case (r_req)
                REQ_LEFT: begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = ADDR_W'(CNT_W'(CAPACITY) - w_after - CNT_W'(1));
                end
                REQ_RIGHT: begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = ADDR_W'(r_cursor);
                end
                default: begin
                    w_wr_en = 1'b0;
                end
            endcase
        end
    end

    cleb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Next cursor, length and result
    always_comb begin
        n_cursor = r_cursor;
        n_length = r_length;
        n_status = ST_DONE;
        n_char   = '0;
        w_load   = 1'b0;
        if (i_cmd.accept && !o_sts.needs_fetch) begin
            w_load = 1'b1;
            case (i_req_type)
                REQ_DELETE: begin
                    if (w_at_start) begin
                        n_status = ST_BOUNDARY;
                    end else begin
                        n_cursor = r_cursor - CNT_W'(1);
                        n_length = r_length - CNT_W'(1);
                    end
                end
                REQ_INSERT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_cursor = r_cursor + CNT_W'(1);
                        n_length = r_length + CNT_W'(1);
                    end
                end
                REQ_READ: begin
                    n_status = ST_RANGE;
                end
                default: begin
                    // moves at a boundary and unused codes
                    n_status = ST_BOUNDARY;
                end
            endcase
        end else if (i_cmd.finish) begin
            w_load = 1'b1;
            case (r_req)
                REQ_LEFT: begin
                    n_cursor = r_cursor - CNT_W'(1);
                end
                REQ_RIGHT: begin
                    n_cursor = r_cursor + CNT_W'(1);
                end
                default: begin
                    n_char = w_rd_data;
                end
            endcase
        end
    end

    // Result register drains on a taken transaction, reloads on completion
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cursor    <= n_cursor;
            r_length    <= n_length;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
        end
        if (w_load) begin
            r_status     <= n_status;
            r_char       <= n_char;
            r_out_length <= n_length;
            r_out_cursor <= n_cursor;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_char   = r_char;
    assign o_text_length = OUT_CNT_W'(r_out_length);
    assign o_cursor_pos  = OUT_CNT_W'(r_out_cursor);

    `CLEB_ASSERT_HOLDS(a_cursor_in_line, r_cursor <= r_length, "cursor beyond line end")
    `CLEB_ASSERT_HOLDS(a_length_cap, r_length <= CNT_W'(CAPACITY), "length above capacity")
    `CLEB_ASSERT_IMPL(a_length_step, $past(i_rst_n),
        (r_length == $past(r_length)) || (r_length == $past(r_length) + CNT_W'(1))
            || (r_length == $past(r_length) - CNT_W'(1)),
        "length moved by more than one")

endmodule

`default_nettype wire
